@@ rtl/core/ffa_pkg.sv @@
package ffa_pkg;

  localparam int unsigned ARENA_UNITS = 4096;
  localparam int unsigned UNIT_BYTES  = 16;
  localparam int unsigned UNIT_SHIFT  = $clog2(UNIT_BYTES);
  localparam int unsigned AW          = 13;   // header index / payload address
  localparam int unsigned SW          = 32;   // block size, wraps like the spec
  localparam int unsigned BW          = 16;   // request byte count
  localparam int unsigned HW          = AW + SW;
  localparam int unsigned FREE_WALK_LIMIT  = ARENA_UNITS + 2;
  localparam int unsigned ALLOC_WALK_LIMIT = 2 * ARENA_UNITS + 8;
  localparam int unsigned ASW         = 14;   // alloc walk counter
  localparam int unsigned ISW         = 13;   // insert walk counter

  typedef logic [4:0] dp_op_t;

  localparam dp_op_t OP_NOP       = 5'd0;
  localparam dp_op_t OP_CLEAR     = 5'd1;
  localparam dp_op_t OP_ACC_ALLOC = 5'd2;
  localparam dp_op_t OP_ACC_FREE  = 5'd3;
  localparam dp_op_t OP_ACC_SKIP  = 5'd4;
  localparam dp_op_t OP_A_HEAD    = 5'd5;
  localparam dp_op_t OP_A_EXACT   = 5'd6;
  localparam dp_op_t OP_A_SPLIT   = 5'd7;
  localparam dp_op_t OP_A_SPLIT2  = 5'd8;
  localparam dp_op_t OP_A_GROW    = 5'd9;
  localparam dp_op_t OP_A_STEP    = 5'd10;
  localparam dp_op_t OP_G_SET     = 5'd11;
  localparam dp_op_t OP_I_STEP    = 5'd12;
  localparam dp_op_t OP_I_BRK     = 5'd13;
  localparam dp_op_t OP_I_BP_MRG  = 5'd14;
  localparam dp_op_t OP_I_BP_PLN  = 5'd15;
  localparam dp_op_t OP_I_NX      = 5'd16;
  localparam dp_op_t OP_I_PV_GROW = 5'd17;
  localparam dp_op_t OP_I_PV_FREE = 5'd18;
  localparam dp_op_t OP_OUT_LOAD  = 5'd19;

  typedef struct packed {
    logic req_free;
    logic addr_ok;
    logic fits;
    logic exact;
    logic at_rover;
    logic grow_ok;
    logic astep_over;
    logic istep_over;
    logic ins_brk;
    logic merge_next;
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/core/ffa_dp.sv @@
module ffa_dp
  import ffa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_op_t        op_i,
  input  logic          req_type_i,
  input  logic [BW-1:0] request_bytes_i,
  input  logic [AW-1:0] block_address_i,
  input  logic          cfg_we_i,
  input  logic [AW-1:0] cfg_wdata_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic          status_o,
  output logic [AW-1:0] payload_address_o,
  output dp_sts_t       sts_o
);

  logic [HW-1:0] mem [0:ARENA_UNITS];
  logic [HW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [HW-1:0] wd;

  logic [AW-1:0] limit_q, limit_d, rover_q, rover_d, bump_q, bump_d, clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  logic          out_status_q, out_status_d;
  logic [AW-1:0] out_addr_q, out_addr_d;
  logic          req_free_q, req_free_d;
  logic [AW-1:0] nun_q, nun_d, bp_q, bp_d, prev_q, prev_d, p_q, p_d;
  logic [AW-1:0] ins_p_q, ins_p_d, ins_n_q, ins_n_d, bpn_next_q, bpn_next_d;
  logic [SW-1:0] prev_sz_q, prev_sz_d, ins_ps_q, ins_ps_d, bs_q, bs_d;
  logic [SW-1:0] bpn_size_q, bpn_size_d, res_q, res_d;
  logic [ASW-1:0] asteps_q, asteps_d;
  logic [ISW-1:0] isteps_q, isteps_d;

  logic [AW-1:0] rd_next;
  logic [SW-1:0] rd_size, p2, pv_size;
  logic [AW-1:0] lim, pv_next, in_nun;
  logic          merge_prev, p2_in_range;

  assign rd_next = rd_q[HW-1:SW];
  assign rd_size = rd_q[SW-1:0];
  assign lim     = (limit_q > AW'(ARENA_UNITS)) ? AW'(ARENA_UNITS) : limit_q;
  assign in_nun  = AW'(({1'b0, request_bytes_i} + (BW+1)'(UNIT_BYTES - 1)) >> UNIT_SHIFT)
                   + AW'(1);
  assign p2      = SW'(p_q) + rd_size - SW'(nun_q);
  assign p2_in_range = res_q <= SW'(ARENA_UNITS);
  assign merge_prev  = (ins_p_q != '0) && ((SW'(ins_p_q) + ins_ps_q) == SW'(bp_q));
  assign pv_size = merge_prev ? ins_ps_q + bpn_size_q : ins_ps_q;
  assign pv_next = merge_prev ? bpn_next_q : bp_q;

  always_comb begin
    sts_o.req_free   = req_type_i;
    sts_o.addr_ok    = (block_address_i != '0) && (block_address_i <= bump_q);
    sts_o.fits       = rd_size >= SW'(nun_q);
    sts_o.exact      = rd_size == SW'(nun_q);
    sts_o.at_rover   = p_q == rover_q;
    sts_o.grow_ok    = (nun_q <= lim) && (bump_q <= lim - nun_q);
    sts_o.astep_over = asteps_q >= ASW'(ALLOC_WALK_LIMIT);
    sts_o.istep_over = isteps_q >= ISW'(FREE_WALK_LIMIT);
    sts_o.ins_brk    = ((bp_q > ins_p_q) && (bp_q < rd_next)) ||
                       ((ins_p_q >= rd_next) && ((bp_q > ins_p_q) || (bp_q < rd_next)));
    sts_o.merge_next = (ins_n_q != '0) && ((SW'(bp_q) + rd_size) == SW'(ins_n_q));
    sts_o.clear_last = clr_q == AW'(ARENA_UNITS);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    limit_d = cfg_we_i ? cfg_wdata_i : limit_q;
    rover_d = rover_q; bump_d = bump_q; clr_d = clr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q; out_addr_d = out_addr_q;
    req_free_d = req_free_q; nun_d = nun_q; bp_d = bp_q; prev_d = prev_q; p_d = p_q;
    ins_p_d = ins_p_q; ins_n_d = ins_n_q; bpn_next_d = bpn_next_q;
    prev_sz_d = prev_sz_q; ins_ps_d = ins_ps_q; bs_d = bs_q;
    bpn_size_d = bpn_size_q; res_d = res_q;
    asteps_d = asteps_q; isteps_d = isteps_q;
    case (op_i)
      OP_CLEAR: begin
        we = 1'b1; wa = clr_q; clr_d = clr_q + AW'(1);
      end
      OP_ACC_ALLOC: begin
        req_free_d = 1'b0; res_d = '0; nun_d = in_nun;
        prev_d = rover_q; asteps_d = '0; ra = rover_q;
      end
      OP_ACC_FREE: begin
        req_free_d = 1'b1; res_d = '0; bp_d = block_address_i;
        ins_p_d = rover_q; isteps_d = '0; ra = rover_q;
      end
      OP_ACC_SKIP: begin
        req_free_d = 1'b1; res_d = '0;
      end
      OP_A_HEAD: begin
        prev_sz_d = rd_size; p_d = rd_next; ra = rd_next;
      end
      OP_A_EXACT: begin
        we = 1'b1; wa = prev_q; wd = {rd_next, prev_sz_q};
        rover_d = prev_q; res_d = SW'(p_q);
      end
      OP_A_SPLIT: begin
        we = 1'b1; wa = p_q; wd = {rd_next, rd_size - SW'(nun_q)};
        rover_d = prev_q; res_d = p2; ra = p2[AW-1:0];
      end
      OP_A_SPLIT2: begin
        // If the carve-out lands beyond the arena, the header write is dropped.
        we = p2_in_range; wa = res_q[AW-1:0]; wd = {rd_next, SW'(nun_q)};
      end
      OP_A_GROW: begin
        bump_d = bump_q + nun_q; bp_d = bump_q + AW'(1); ra = bump_q + AW'(1);
        ins_p_d = rover_q; isteps_d = '0;
      end
      OP_A_STEP: begin
        prev_d = p_q; prev_sz_d = rd_size; p_d = rd_next; ra = rd_next;
        asteps_d = asteps_q + ASW'(1);
      end
      OP_G_SET: begin
        we = 1'b1; wa = bp_q; wd = {rd_next, SW'(nun_q)}; ra = rover_q;
      end
      OP_I_STEP: begin
        ins_p_d = rd_next; ra = rd_next; isteps_d = isteps_q + ISW'(1);
      end
      OP_I_BRK: begin
        ins_n_d = rd_next; ins_ps_d = rd_size; ra = bp_q;
      end
      OP_I_BP_MRG: begin
        bs_d = rd_size; ra = ins_n_q;
      end
      OP_I_BP_PLN: begin
        we = 1'b1; wa = bp_q; wd = {ins_n_q, rd_size};
        bpn_next_d = ins_n_q; bpn_size_d = rd_size;
      end
      OP_I_NX: begin
        we = 1'b1; wa = bp_q; wd = {rd_next, bs_q + rd_size};
        bpn_next_d = rd_next; bpn_size_d = bs_q + rd_size;
      end
      OP_I_PV_GROW: begin
        we = 1'b1; wa = ins_p_q; wd = {pv_next, pv_size}; rover_d = ins_p_q;
        prev_d = ins_p_q; prev_sz_d = pv_size; p_d = pv_next; ra = pv_next;
        asteps_d = asteps_q + ASW'(1);
      end
      OP_I_PV_FREE: begin
        we = 1'b1; wa = ins_p_q; wd = {pv_next, pv_size}; rover_d = ins_p_q;
      end
      OP_OUT_LOAD: begin
        out_valid_d  = 1'b1;
        out_status_d = !req_free_q && (res_q == '0);
        out_addr_d   = req_free_q ? '0 : res_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= (we && (wa == ra)) ? wd : mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= AW'(ARENA_UNITS);
      rover_q     <= '0;
      bump_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      rover_q     <= rover_d;
      bump_q      <= bump_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d; out_addr_q <= out_addr_d;
    req_free_q <= req_free_d; nun_q <= nun_d; bp_q <= bp_d; prev_q <= prev_d; p_q <= p_d;
    ins_p_q <= ins_p_d; ins_n_q <= ins_n_d; bpn_next_q <= bpn_next_d;
    prev_sz_q <= prev_sz_d; ins_ps_q <= ins_ps_d; bs_q <= bs_d;
    bpn_size_q <= bpn_size_d; res_q <= res_d;
    asteps_q <= asteps_d; isteps_q <= isteps_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign payload_address_o = out_addr_q;

endmodule

@@ rtl/core/ffa_ctrl.sv @@
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  dp_sts_t sts_i,
  output logic    in_stall_o,
  output dp_op_t  op_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_HEAD = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_A_SPL2 = 4'd4;
  localparam logic [3:0] S_G_SET  = 4'd5;
  localparam logic [3:0] S_I_WALK = 4'd6;
  localparam logic [3:0] S_I_BP   = 4'd7;
  localparam logic [3:0] S_I_NX   = 4'd8;
  localparam logic [3:0] S_I_PV   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_q, state_d;
  logic       grow_q, grow_d;   // insert walk runs on behalf of a bump

  always_comb begin
    state_d = state_q;
    grow_d  = grow_q;
    op_o    = OP_NOP;
    case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (!sts_i.req_free) begin
            op_o = OP_ACC_ALLOC; state_d = S_A_HEAD;
          end else if (sts_i.addr_ok) begin
            op_o = OP_ACC_FREE; grow_d = 1'b0; state_d = S_I_WALK;
          end else begin
            op_o = OP_ACC_SKIP; state_d = S_FIN;
          end
        end
      end
      S_A_HEAD: begin
        op_o = OP_A_HEAD; state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts_i.fits) begin
          if (sts_i.exact) begin
            op_o = OP_A_EXACT; state_d = S_FIN;
          end else begin
            op_o = OP_A_SPLIT; state_d = S_A_SPL2;
          end
        end else if (sts_i.at_rover) begin
          if (sts_i.grow_ok) begin
            op_o = OP_A_GROW; state_d = S_G_SET;
          end else begin
            state_d = S_FIN;
          end
        end else if (sts_i.astep_over) begin
          state_d = S_FIN;
        end else begin
          op_o = OP_A_STEP;
        end
      end
      S_A_SPL2: begin
        op_o = OP_A_SPLIT2; state_d = S_FIN;
      end
      S_G_SET: begin
        op_o = OP_G_SET; grow_d = 1'b1; state_d = S_I_WALK;
      end
      S_I_WALK: begin
        if (sts_i.ins_brk) begin
          op_o = OP_I_BRK; state_d = S_I_BP;
        end else if (sts_i.istep_over) begin
          state_d = S_FIN;
        end else begin
          op_o = OP_I_STEP;
        end
      end
      S_I_BP: begin
        if (sts_i.merge_next) begin
          op_o = OP_I_BP_MRG; state_d = S_I_NX;
        end else begin
          op_o = OP_I_BP_PLN; state_d = S_I_PV;
        end
      end
      S_I_NX: begin
        op_o = OP_I_NX; state_d = S_I_PV;
      end
      S_I_PV: begin
        if (grow_q) begin
          op_o = OP_I_PV_GROW;
          state_d = sts_i.astep_over ? S_FIN : S_A_CHK;
        end else begin
          op_o = OP_I_PV_FREE; state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          op_o = OP_OUT_LOAD; state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      grow_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grow_q  <= grow_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule

@@ rtl/core/first_fit_free_list_allocator_top.sv @@
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  req_type_i, request_bytes_i, block_address_i
// result    out        out_valid_o/out_stall_i status_o, payload_address_o
// config    in         cfg_we_i               cfg_wdata_i (arena limit in units)
//
// Every header access is one read of the header memory, which has a write
// port beside its read port, so a transaction walks the free list node by
// node: an allocate walks N nodes, and when it bumps fresh units an insert
// walk of M more nodes follows; a free walks M nodes. After reset the header
// memory is swept to zero with in_stall_o high. A waiting result holds the
// block in its final state only when a second result is ready.
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          req_type_i,
  input  logic [BW-1:0] request_bytes_i,
  input  logic [AW-1:0] block_address_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          status_o,
  output logic [AW-1:0] payload_address_o,
  input  logic          cfg_we_i,
  input  logic [AW-1:0] cfg_wdata_i
);

  dp_op_t  op;
  dp_sts_t sts;

  // Sequence each transaction: walk, split, bump, insert and merge.
  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .op_o       (op)
  );

  // Hold the header memory, rover, bump pointer and the result register.
  ffa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .req_type_i        (req_type_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .sts_o             (sts)
  );

endmodule
